[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the Huffman code builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define HCB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks a condition in the cycle after a trigger.
`define HCB_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hw/rtl/hcb_pkg.sv]
// Package with the constants and types of the Huffman code builder.
package hcb_pkg;
    localparam int MAX_SYMBOLS = 64;
    localparam int FREQ_BITS   = 24;
    localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
    localparam int SYM_W       = 8;
    localparam int FREQ_W      = 24;
    localparam int WEIGHT_W    = 30;
    localparam int NODE_W      = 7;
    localparam int LEAF_AW     = 6;
    localparam int DEPTH_W     = 6;
    localparam int CODE_W      = 63;
    localparam int COUNT_W     = 7;
    localparam int WENTRY_W    = WEIGHT_W + 1;
    localparam int CHILD_W     = 2 * NODE_W;
    localparam int STACK_W     = CODE_W + DEPTH_W + NODE_W;

    typedef struct packed {
        logic                have1;
        logic                have2;
        logic [WEIGHT_W-1:0] w1;
        logic [NODE_W-1:0]   i1;
        logic [WEIGHT_W-1:0] w2;
        logic [NODE_W-1:0]   i2;
    } pair_t;
endpackage

[hw/rtl/hcb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/hcb_min2.sv]
// Tracker of the two lightest live nodes seen during one scan of the weight memory.
module hcb_min2 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         in_valid,
    input  logic [hcb_pkg::NODE_W-1:0]   in_idx,
    input  logic                         in_alive,
    input  logic [hcb_pkg::WEIGHT_W-1:0] in_weight,
    output hcb_pkg::pair_t               pair
);
    hcb_pkg::pair_t pair_reg;
    hcb_pkg::pair_t pair_next;

    // Indices arrive in increasing order, so a tie keeps the earlier node.
    always_comb begin
        pair_next = pair_reg;
        if (clear) begin
            pair_next.have1 = 1'b0;
            pair_next.have2 = 1'b0;
        end else if (in_valid && in_alive) begin
            if (!pair_reg.have1 || in_weight < pair_reg.w1) begin
                pair_next.have2 = pair_reg.have1;
                pair_next.w2    = pair_reg.w1;
                pair_next.i2    = pair_reg.i1;
                pair_next.have1 = 1'b1;
                pair_next.w1    = in_weight;
                pair_next.i1    = in_idx;
            end else if (!pair_reg.have2 || in_weight < pair_reg.w2) begin
                pair_next.have2 = 1'b1;
                pair_next.w2    = in_weight;
                pair_next.i2    = in_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg.have1 <= 1'b0;
            pair_reg.have2 <= 1'b0;
        end else begin
            pair_reg <= pair_next;
        end
    end

    assign pair = pair_reg;
endmodule

[hw/rtl/huffman_code_builder_core.sv]
// Top level of the Huffman code builder: load, tree build and code walk.
// Usage: symbol and frequency items enter on the s_ channel, one per cycle while
// s_tready is high, until an item with s_tlast set. Up to 64 symbols are kept;
// further items are dropped, but a dropped item with s_tlast still starts the build.
// s_tready stays low from then until the last code has been taken.
// The build scans the weight memory once per merge, one entry per cycle over every
// node made so far, then closes the merge in the tail and three merge states, paced
// by the single read port of that memory. Through the stack memory, the walk visits
// internal nodes in the node and child states, leaves in the node, symbol, emit, pop
// and pop-data states, giving one code per leaf on m_ with m_tlast on the final one.
// A lone symbol gets length zero.
// A code waits in the output register until m_tready; the walk stalls meanwhile.
// Reset returns the block to loading with an empty set; no clearing pass is needed.
`include "assert_macros.svh"
module huffman_code_builder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // symbol[7:0], frequency[31:8]
    input  logic        s_tlast,  // last_symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // code_symbol[7:0], code_bits[70:8], code_length[76:71]
    output logic        m_tlast   // last_code
);
    typedef enum logic [11:0] {
        ST_LOAD   = 12'b000000000001,
        ST_SCAN   = 12'b000000000010,
        ST_TAIL   = 12'b000000000100,
        ST_MERGE1 = 12'b000000001000,
        ST_MERGE2 = 12'b000000010000,
        ST_MERGE3 = 12'b000000100000,
        ST_POP    = 12'b000001000000,
        ST_POPD   = 12'b000010000000,
        ST_NODE   = 12'b000100000000,
        ST_CHILD  = 12'b001000000000,
        ST_SYM    = 12'b010000000000,
        ST_EMIT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [hcb_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [hcb_pkg::COUNT_W-1:0] n_reg, n_next;
    logic [hcb_pkg::NODE_W-1:0]  next_node_reg, next_node_next;
    logic [hcb_pkg::COUNT_W-1:0] active_reg, active_next;
    logic [hcb_pkg::NODE_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                        pend_reg, pend_next;
    logic [hcb_pkg::NODE_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [hcb_pkg::COUNT_W-1:0] sp_reg, sp_next;
    logic [hcb_pkg::NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic [hcb_pkg::DEPTH_W-1:0] cur_depth_reg, cur_depth_next;
    logic [hcb_pkg::CODE_W-1:0]  cur_bits_reg, cur_bits_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_last_reg, m_last_next;
    logic [hcb_pkg::SYM_W-1:0]   out_sym_reg, out_sym_next;
    logic [hcb_pkg::CODE_W-1:0]  out_bits_reg, out_bits_next;
    logic [hcb_pkg::DEPTH_W-1:0] out_len_reg, out_len_next;

    logic                        accept;
    logic                        stored;
    logic [hcb_pkg::COUNT_W-1:0] count_after;
    logic                        min_clear;
    hcb_pkg::pair_t              pair;

    logic                         w_we;
    logic [hcb_pkg::NODE_W-1:0]   w_waddr;
    logic [hcb_pkg::WENTRY_W-1:0] w_wdata;
    logic [hcb_pkg::WENTRY_W-1:0] w_rdata;
    logic                         s_we;
    logic [hcb_pkg::SYM_W-1:0]    s_rdata;
    logic                         c_we;
    logic [hcb_pkg::LEAF_AW-1:0]  c_waddr;
    logic [hcb_pkg::LEAF_AW-1:0]  c_raddr;
    logic [hcb_pkg::CHILD_W-1:0]  c_rdata;
    logic                         k_we;
    logic [hcb_pkg::LEAF_AW-1:0]  k_raddr;
    logic [hcb_pkg::STACK_W-1:0]  k_wdata;
    logic [hcb_pkg::STACK_W-1:0]  k_rdata;
    logic [hcb_pkg::NODE_W-1:0]   child_off;
    logic [hcb_pkg::WEIGHT_W-1:0] sum;

    assign accept      = s_tvalid && s_tready;
    assign stored      = (count_reg < hcb_pkg::COUNT_W'(hcb_pkg::MAX_SYMBOLS));
    assign count_after = count_reg + hcb_pkg::COUNT_W'(stored);
    assign child_off   = cur_node_reg - n_reg;
    assign c_raddr     = child_off[hcb_pkg::LEAF_AW-1:0];
    assign k_raddr     = sp_reg[hcb_pkg::LEAF_AW-1:0] - hcb_pkg::LEAF_AW'(1);
    assign sum         = pair.w1 + pair.w2;

    hcb_ram #(.WIDTH(hcb_pkg::WENTRY_W), .DEPTH(hcb_pkg::NODE_COUNT + 1)) u_weights (
        .clk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(scan_idx_reg), .rdata(w_rdata)
    );

    hcb_ram #(.WIDTH(hcb_pkg::SYM_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_symbols (
        .clk(aclk), .we(s_we), .waddr(count_reg[hcb_pkg::LEAF_AW-1:0]),
        .wdata(s_tdata[hcb_pkg::SYM_W-1:0]),
        .raddr(cur_node_reg[hcb_pkg::LEAF_AW-1:0]), .rdata(s_rdata)
    );

    hcb_ram #(.WIDTH(hcb_pkg::CHILD_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_children (
        .clk(aclk), .we(c_we), .waddr(c_waddr), .wdata({pair.i1, pair.i2}),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    hcb_ram #(.WIDTH(hcb_pkg::STACK_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_stack (
        .clk(aclk), .we(k_we), .waddr(sp_reg[hcb_pkg::LEAF_AW-1:0]), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    hcb_min2 u_min2 (
        .aclk(aclk), .aresetn(aresetn), .clear(min_clear),
        .in_valid(pend_reg), .in_idx(pend_idx_reg),
        .in_alive(w_rdata[hcb_pkg::WEIGHT_W]),
        .in_weight(w_rdata[hcb_pkg::WEIGHT_W-1:0]), .pair(pair)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        next_node_next = next_node_reg;
        active_next    = active_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = scan_idx_reg;
        sp_next        = sp_reg;
        cur_node_next  = cur_node_reg;
        cur_depth_next = cur_depth_reg;
        cur_bits_next  = cur_bits_reg;
        m_valid_next   = m_valid_reg;
        m_last_next    = m_last_reg;
        out_sym_next   = out_sym_reg;
        out_bits_next  = out_bits_reg;
        out_len_next   = out_len_reg;
        min_clear      = 1'b0;
        w_we           = 1'b0;
        w_waddr        = count_reg;
        w_wdata        = {1'b1, hcb_pkg::WEIGHT_W'(s_tdata[8 +: hcb_pkg::FREQ_BITS])};
        s_we           = 1'b0;
        c_we           = 1'b0;
        c_waddr        = child_off[hcb_pkg::LEAF_AW-1:0];
        k_we           = 1'b0;
        k_wdata        = {{cur_bits_reg[hcb_pkg::CODE_W-2:0], 1'b1},
                          cur_depth_reg + hcb_pkg::DEPTH_W'(1),
                          c_rdata[hcb_pkg::NODE_W-1:0]};
        s_tready       = (state_reg == ST_LOAD);

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    w_we       = stored;
                    s_we       = stored;
                    count_next = count_after;
                    if (s_tlast) begin
                        count_next     = '0;
                        n_next         = count_after;
                        next_node_next = count_after;
                        active_next    = count_after;
                        scan_idx_next  = '0;
                        min_clear      = 1'b1;
                        sp_next        = '0;
                        cur_node_next  = '0;
                        cur_depth_next = '0;
                        cur_bits_next  = '0;
                        if (count_after == hcb_pkg::COUNT_W'(1)) begin
                            state_next = ST_NODE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                pend_next     = 1'b1;
                scan_idx_next = scan_idx_reg + hcb_pkg::NODE_W'(1);
                if (scan_idx_reg == next_node_reg - hcb_pkg::NODE_W'(1)) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = ST_MERGE1;
            end
            ST_MERGE1: begin
                w_we       = 1'b1;
                w_waddr    = pair.i1;
                w_wdata    = '0;
                c_we       = 1'b1;
                c_waddr    = hcb_pkg::LEAF_AW'(next_node_reg - n_reg);
                state_next = ST_MERGE2;
            end
            ST_MERGE2: begin
                w_we       = 1'b1;
                w_waddr    = pair.i2;
                w_wdata    = '0;
                state_next = ST_MERGE3;
            end
            ST_MERGE3: begin
                w_we           = 1'b1;
                w_waddr        = next_node_reg;
                w_wdata        = {1'b1, sum};
                next_node_next = next_node_reg + hcb_pkg::NODE_W'(1);
                active_next    = active_reg - hcb_pkg::COUNT_W'(1);
                scan_idx_next  = '0;
                min_clear      = 1'b1;
                cur_node_next  = next_node_reg;
                if (active_reg == hcb_pkg::COUNT_W'(2)) begin
                    state_next = ST_NODE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    state_next = ST_LOAD;
                end else begin
                    sp_next    = sp_reg - hcb_pkg::COUNT_W'(1);
                    state_next = ST_POPD;
                end
            end
            ST_POPD: begin
                cur_bits_next  = k_rdata[hcb_pkg::STACK_W-1 -: hcb_pkg::CODE_W];
                cur_depth_next = k_rdata[hcb_pkg::NODE_W +: hcb_pkg::DEPTH_W];
                cur_node_next  = k_rdata[hcb_pkg::NODE_W-1:0];
                state_next     = ST_NODE;
            end
            ST_NODE: begin
                if (cur_node_reg < n_reg) begin
                    state_next = ST_SYM;
                end else begin
                    state_next = ST_CHILD;
                end
            end
            ST_CHILD: begin
                k_we           = 1'b1;
                sp_next        = sp_reg + hcb_pkg::COUNT_W'(1);
                cur_node_next  = c_rdata[hcb_pkg::CHILD_W-1 -: hcb_pkg::NODE_W];
                cur_depth_next = cur_depth_reg + hcb_pkg::DEPTH_W'(1);
                cur_bits_next  = {cur_bits_reg[hcb_pkg::CODE_W-2:0], 1'b0};
                state_next     = ST_NODE;
            end
            ST_SYM: begin
                out_sym_next  = s_rdata;
                out_bits_next = cur_bits_reg;
                out_len_next  = cur_depth_reg;
                m_last_next   = (sp_reg == '0);
                m_valid_next  = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_POP;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        next_node_reg <= next_node_next;
        active_reg    <= active_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        sp_reg        <= sp_next;
        cur_node_reg  <= cur_node_next;
        cur_depth_reg <= cur_depth_next;
        cur_bits_reg  <= cur_bits_next;
        m_last_reg    <= m_last_next;
        out_sym_reg   <= out_sym_next;
        out_bits_reg  <= out_bits_next;
        out_len_reg   <= out_len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_bits_reg, out_sym_reg};

    `HCB_ASSERT_ALWAYS(a_valid_in_emit, (m_valid_reg == (state_reg == ST_EMIT)), "output valid outside emit")
    `HCB_ASSERT_ALWAYS(a_pair_found, (!(state_reg == ST_MERGE1 || state_reg == ST_MERGE2 || state_reg == ST_MERGE3) || (pair.have1 && pair.have2)), "merge without two live nodes")
    `HCB_ASSERT_NEXT(a_active_drops, (state_reg == ST_MERGE3), (active_reg == $past(active_reg) - hcb_pkg::COUNT_W'(1)), "merge did not shrink the live set")
endmodule

[tb/testbench.sv]
// Self-checking testbench for the Huffman code builder core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [hcb_pkg::SYM_W-1:0]   sym;
        logic [hcb_pkg::CODE_W-1:0]  bits;
        logic [hcb_pkg::DEPTH_W-1:0] len;
        logic                        last;
    } code_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    huffman_code_builder_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    code_t               expected_codes[$];
    int                  mismatches;
    int                  gap_max;
    int                  sink_stall;
    int                  items_sent;

    int                           set_size;
    logic [hcb_pkg::SYM_W-1:0]    set_symbols[hcb_pkg::MAX_SYMBOLS];
    logic [hcb_pkg::WEIGHT_W-1:0] node_w[hcb_pkg::NODE_COUNT];
    int                           kid_l[hcb_pkg::MAX_SYMBOLS];
    int                           kid_r[hcb_pkg::MAX_SYMBOLS];
    int                           live_nodes[hcb_pkg::MAX_SYMBOLS];
    int                           live_count;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int take_lightest();
        int best;
        int node;
        best = 0;
        for (int i = 1; i < live_count; i++) begin
            if (node_w[live_nodes[i]] < node_w[live_nodes[best]] ||
                (node_w[live_nodes[i]] == node_w[live_nodes[best]] &&
                 live_nodes[i] < live_nodes[best])) begin
                best = i;
            end
        end
        node = live_nodes[best];
        live_count--;
        live_nodes[best] = live_nodes[live_count];
        return node;
    endfunction

    function automatic void build_codes();
        int          n;
        int          next_node;
        int          a;
        int          b;
        int          sp;
        int          node;
        int          depth;
        int          emitted;
        logic [63:0] path;
        int          st_node[hcb_pkg::MAX_SYMBOLS];
        int          st_depth[hcb_pkg::MAX_SYMBOLS];
        logic [63:0] st_path[hcb_pkg::MAX_SYMBOLS];
        code_t       c;
        n = set_size;
        next_node = n;
        live_count = n;
        emitted = 0;
        for (int i = 0; i < n; i++) live_nodes[i] = i;
        while (live_count > 1) begin
            a = take_lightest();
            b = take_lightest();
            node_w[next_node] = node_w[a] + node_w[b];
            kid_l[next_node - n] = a;
            kid_r[next_node - n] = b;
            live_nodes[live_count] = next_node;
            live_count++;
            next_node++;
        end
        st_node[0] = next_node - 1;
        st_depth[0] = 0;
        st_path[0] = '0;
        sp = 1;
        while (sp > 0) begin
            sp--;
            node = st_node[sp];
            depth = st_depth[sp];
            path = st_path[sp];
            if (node < n) begin
                c.sym = set_symbols[node];
                c.bits = path[hcb_pkg::CODE_W-1:0];
                c.len = depth[hcb_pkg::DEPTH_W-1:0];
                c.last = 1'b0;
                expected_codes.push_back(c);
                emitted++;
            end else if (sp + 2 <= hcb_pkg::MAX_SYMBOLS) begin
                st_node[sp] = kid_r[node - n];
                st_depth[sp] = depth + 1;
                st_path[sp] = (path << 1) | 64'd1;
                sp++;
                st_node[sp] = kid_l[node - n];
                st_depth[sp] = depth + 1;
                st_path[sp] = path << 1;
                sp++;
            end
        end
        if (emitted > 0) expected_codes[expected_codes.size() - 1].last = 1'b1;
        set_size = 0;
    endfunction

    function automatic void accept_symbol(logic [hcb_pkg::SYM_W-1:0] sym,
                                          logic [hcb_pkg::FREQ_W-1:0] freq,
                                          logic last);
        if (set_size < hcb_pkg::MAX_SYMBOLS) begin
            set_symbols[set_size] = sym;
            node_w[set_size] = hcb_pkg::WEIGHT_W'(freq);
            set_size++;
        end
        if (last) build_codes();
    endfunction

    task automatic send_item(logic [hcb_pkg::SYM_W-1:0] sym, logic [hcb_pkg::FREQ_W-1:0] freq,
                             logic last);
        int gap;
        gap = $urandom_range(gap_max, 0);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {freq, sym};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        accept_symbol(sym, freq, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        code_t want;
        if (aresetn && m_tvalid && m_tready) begin
            sink_stall <= $urandom_range(gap_max, 0);
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected code item, got sym %h bits %h len %0d last %b",
                         $time, m_tdata[7:0], m_tdata[70:8], m_tdata[76:71], m_tlast);
                mismatches++;
            end else begin
                want = expected_codes.pop_front();
                if (m_tdata[7:0] !== want.sym) begin
                    $display("%0t: code_symbol expected %h got %h", $time, want.sym,
                             m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[70:8] !== want.bits) begin
                    $display("%0t: code_bits expected %h got %h", $time, want.bits,
                             m_tdata[70:8]);
                    mismatches++;
                end
                if (m_tdata[76:71] !== want.len) begin
                    $display("%0t: code_length expected %0d got %0d", $time, want.len,
                             m_tdata[76:71]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_code expected %b got %b", $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_lone_symbol();
        send_item(8'h00, 24'h000000, 1'b1);
        send_item(8'hFF, 24'hFFFFFF, 1'b1);
        drain();
    endtask

    task automatic test_small_sets();
        send_item(8'h41, 24'd5, 1'b0);
        send_item(8'h42, 24'd3, 1'b1);
        send_item(8'h10, 24'd0, 1'b0);
        send_item(8'h11, 24'd0, 1'b0);
        send_item(8'h12, 24'd0, 1'b1);
        send_item(8'h24, 24'd7, 1'b0);
        send_item(8'h24, 24'd7, 1'b0);
        send_item(8'h24, 24'd7, 1'b0);
        send_item(8'h24, 24'd7, 1'b1);
        send_item(8'hFF, 24'hFFFFFF, 1'b0);
        send_item(8'h00, 24'hFFFFFF, 1'b0);
        send_item(8'hAA, 24'h000001, 1'b1);
        drain();
    endtask

    task automatic test_skewed_tree();
        send_item(8'h80, 24'd1, 1'b0);
        for (int i = 0; i < 24; i++) send_item(8'(8'h81 + i), 24'(1 << i), i == 23);
        drain();
    endtask

    task automatic test_full_buffer();
        for (int i = 0; i < hcb_pkg::MAX_SYMBOLS; i++)
            send_item(8'($urandom), 24'($urandom), i == hcb_pkg::MAX_SYMBOLS - 1);
        drain();
        for (int i = 0; i < hcb_pkg::MAX_SYMBOLS + 6; i++)
            send_item(8'($urandom), 24'($urandom_range(20, 0)),
                      i == hcb_pkg::MAX_SYMBOLS + 5);
        drain();
    endtask

    task automatic test_random_sets(int target);
        int                         n;
        int                         kind;
        logic [hcb_pkg::FREQ_W-1:0] f;
        while (items_sent < target) begin
            n = ($urandom_range(15, 0) == 0) ? $urandom_range(hcb_pkg::MAX_SYMBOLS, 20)
                                             : $urandom_range(10, 1);
            kind = $urandom_range(2, 0);
            gap_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
            for (int i = 0; i < n; i++) begin
                case (kind)
                    0: f = 24'($urandom);
                    1: f = 24'($urandom_range(4, 0));
                    default: f = 24'($urandom) >> $urandom_range(23, 0);
                endcase
                send_item(8'($urandom), f, i == n - 1);
            end
            drain();
        end
    endtask

    initial begin
        #20ms;
        $display("** huffman_code_builder_core: FAILED **");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        sink_stall = 0;
        items_sent = 0;
        set_size = 0;
        gap_max = 5;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_lone_symbol();
        test_small_sets();
        gap_max = 0;
        test_skewed_tree();
        gap_max = 5;
        test_full_buffer();
        test_random_sets(470);
        drain();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** huffman_code_builder_core: PASSED **");
        end else begin
            $display("** huffman_code_builder_core: FAILED **");
        end
        $finish;
    end
endmodule
